// File: design/assert_macros.svh
// Assertion macros shared by the overlap edge finder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AST_IMPL(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// Implication whose consequent is checked in the next cycle.
`define AST_NEXT(lbl, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// File: design/coef_pkg.sv
// Package: types, constants and state codes for the overlap edge finder.
package coef_pkg;
  localparam int MAX_READERS_DEF = 32;
  localparam int ID_W = 16;
  localparam int POS_W = 24;
  localparam int RAD_W = 23;
  localparam int WGT_W = 17;
  localparam int DIFF_W = 25;
  localparam int D2_W = 51;
  localparam int RS_W = 24;
  localparam int SQ_W = 34;
  localparam int DEN_W = 35;
  localparam int NUM_W = 51;
  localparam int ENT_W = ID_W + 2 * POS_W + RAD_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_DIFF, ST_SQR, ST_TEST, ST_SQRT, ST_DIV, ST_EMIT, ST_STORE
  } coef_state_t;

  typedef struct packed {
    logic start;
    logic [D2_W-1:0] d2;
  } coef_calc_req_t;

  typedef struct packed {
    logic done;
    logic [WGT_W-1:0] weight;
  } coef_calc_rsp_t;
endpackage

// File: design/coef_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module coef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: design/coef_weight.sv
// Iterative unit: sqrt of d2<<16, then rounded reciprocal 2^32/(2^16+q).
module coef_weight import coef_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  coef_calc_req_t req,
  output coef_calc_rsp_t rsp
);
  logic             busy_r, busy_nxt;
  logic             phase_r, phase_nxt;
  logic [5:0]       cnt_r, cnt_nxt;
  logic [67:0]      rad_r, rad_nxt;
  logic [SQ_W-1:0]  root_r, root_nxt;
  logic [SQ_W+1:0]  rem_r, rem_nxt;
  logic [DEN_W-1:0] den_r, den_nxt;
  logic [NUM_W-1:0] num_r, num_nxt;
  logic [DEN_W:0]   drem_r, drem_nxt;
  logic [WGT_W-1:0] quo_r, quo_nxt;
  logic             done_r, done_nxt;
  logic [SQ_W+1:0]  trial;
  logic [DEN_W:0]   dsh;

  // Restoring sqrt, two radicand bits per step; then restoring divide, one bit per step.
  always_comb begin
    busy_nxt = busy_r;
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    rad_nxt = rad_r;
    root_nxt = root_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    num_nxt = num_r;
    drem_nxt = drem_r;
    quo_nxt = quo_r;
    done_nxt = 1'b0;
    trial = '0;
    dsh = '0;
    if (!busy_r) begin
      if (req.start) begin
        busy_nxt = 1'b1;
        phase_nxt = 1'b0;
        cnt_nxt = 6'd0;
        rad_nxt = {1'b0, req.d2, 16'd0};
        root_nxt = '0;
        rem_nxt = '0;
      end
    end else if (!phase_r) begin
      rem_nxt = {rem_r[SQ_W-1:0], rad_r[67:66]};
      trial = {root_r, 2'b01};
      if ({rem_r[SQ_W-1:0], rad_r[67:66]} >= trial) begin
        rem_nxt = {rem_r[SQ_W-1:0], rad_r[67:66]} - trial;
        root_nxt = {root_r[SQ_W-2:0], 1'b1};
      end else begin
        root_nxt = {root_r[SQ_W-2:0], 1'b0};
      end
      rad_nxt = {rad_r[65:0], 2'b00};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd33) begin
        phase_nxt = 1'b1;
        cnt_nxt = 6'd0;
      end
    end else if (cnt_r == 6'd0) begin
      den_nxt = DEN_W'(65536) + DEN_W'(root_r);
      num_nxt = NUM_W'(64'h1_0000_0000) + NUM_W'(root_r >> 1) + NUM_W'(32768);
      drem_nxt = '0;
      quo_nxt = '0;
      cnt_nxt = 6'd1;
    end else begin
      dsh = {drem_r[DEN_W-1:0], num_r[NUM_W-1]};
      num_nxt = {num_r[NUM_W-2:0], 1'b0};
      if (dsh >= {1'b0, den_r}) begin
        drem_nxt = dsh - {1'b0, den_r};
        quo_nxt = {quo_r[WGT_W-2:0], 1'b1};
      end else begin
        drem_nxt = dsh;
        quo_nxt = {quo_r[WGT_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(NUM_W)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      phase_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
    end
    rad_r <= rad_nxt;
    root_r <= root_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    num_r <= num_nxt;
    drem_r <= drem_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.weight = quo_r;
endmodule

// File: design/coverage_overlap_edge_finder.sv
// Top level: overlap edge finder over a stored reader table.
//  channel | direction | handshake          | payload
//  in_     | input     | in_valid/in_stall  | start_of_set, node_id, pos, coverage, online
//  out_    | output    | out_valid/out_stall| from_reader, to_reader, weight, last_of_run
// Each online record is accepted, then walks every stored entry (read, difference,
// square, test) and is then stored; an overlap goes through the sqrt/divide unit
// (34 root steps, 1 setup, 51 divide steps, 1 result) and is then emitted.
// The table sits in one RAM with a registered read; one read per entry.
// Reset (synchronous, rst_n low) empties the table count; entries are not cleared.
// A stalled result holds the walk; the input is stalled until the record is stored.
`include "assert_macros.svh"
module coverage_overlap_edge_finder import coef_pkg::*; #(
  parameter int MAX_READERS = MAX_READERS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic                    in_start_of_set,
  input  logic [ID_W-1:0]         in_node_id,
  input  logic signed [POS_W-1:0] in_pos_x,
  input  logic signed [POS_W-1:0] in_pos_y,
  input  logic [RAD_W-1:0]        in_coverage,
  input  logic                    in_online,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [ID_W-1:0]         out_from_reader,
  output logic [ID_W-1:0]         out_to_reader,
  output logic [WGT_W-1:0]        out_weight,
  output logic                    out_last_of_run
);
  localparam int AW = $clog2(MAX_READERS);
  localparam int CW = $clog2(MAX_READERS + 1);

  coef_state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] nedge_r, nedge_nxt;
  logic [ID_W-1:0] id_r;
  logic signed [POS_W-1:0] x_r, y_r;
  logic [RAD_W-1:0] rad_r;
  logic [DIFF_W-1:0] dx_r, dy_r;
  logic [RS_W-1:0] rs_r;
  logic [D2_W-1:0] d2_r;
  logic [2*RS_W-1:0] rs2_r;
  logic [ID_W-1:0] eid_r;
  logic pend_r, pend_nxt;
  logic [ID_W-1:0] pfrom_r;
  logic [WGT_W-1:0] pw_r;
  logic ov_r, ov_nxt;
  logic accept, go_emit;
  logic [ENT_W-1:0] rdata, wdata;
  logic we;
  logic signed [POS_W-1:0] ex, ey;
  logic [RAD_W-1:0] er;
  logic [ID_W-1:0] eid;
  logic signed [DIFF_W-1:0] sdx, sdy;
  logic [2*DIFF_W-1:0] dxx, dyy;
  coef_calc_req_t creq;
  coef_calc_rsp_t crsp;

  assign {eid, ex, ey, er} = rdata;
  assign wdata = {id_r, x_r, y_r, rad_r};
  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign sdx = DIFF_W'(x_r) - DIFF_W'(ex);
  assign sdy = DIFF_W'(y_r) - DIFF_W'(ey);
  assign dxx = dx_r * dx_r;
  assign dyy = dy_r * dy_r;
  // An edge can leave once the output register is free.
  assign go_emit = (st_r == ST_EMIT) && !(ov_r && out_stall);
  assign we = (st_r == ST_STORE) && (cnt_r < CW'(MAX_READERS));

  coef_ram #(.WIDTH(ENT_W), .DEPTH(MAX_READERS)) u_ram (
    .clk(clk), .we(we), .waddr(cnt_r[AW-1:0]), .wdata(wdata),
    .raddr(idx_r[AW-1:0]), .rdata(rdata)
  );

  assign creq.start = (st_r == ST_TEST) && (d2_r <= D2_W'(rs2_r))
                      && (nedge_r < CW'(MAX_READERS - 1));
  assign creq.d2 = d2_r;

  coef_weight u_weight (.clk(clk), .rst_n(rst_n), .req(creq), .rsp(crsp));

  // Next state.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: begin
        if (accept && in_online) begin
          st_nxt = ((in_start_of_set ? CW'(0) : cnt_r) == '0) ? ST_STORE : ST_READ;
        end
      end
      ST_READ: st_nxt = ST_DIFF;
      ST_DIFF: st_nxt = ST_SQR;
      ST_SQR: st_nxt = ST_TEST;
      ST_TEST: begin
        if (creq.start) begin
          st_nxt = ST_SQRT;
        end else if (idx_r + CW'(1) >= cnt_r) begin
          st_nxt = ST_STORE;
        end else begin
          st_nxt = ST_READ;
        end
      end
      ST_SQRT: if (crsp.done) st_nxt = ST_EMIT;
      ST_DIV: st_nxt = ST_EMIT;
      ST_EMIT: begin
        if (go_emit) begin
          st_nxt = (idx_r + CW'(1) >= cnt_r) ? ST_STORE : ST_READ;
        end
      end
      ST_STORE: begin
        if (!(ov_r && out_stall)) st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Counters, pending edge and output register.
  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    nedge_nxt = nedge_r;
    pend_nxt = pend_r;
    ov_nxt = ov_r;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_start_of_set) cnt_nxt = '0;
          idx_nxt = '0;
          nedge_nxt = '0;
          pend_nxt = 1'b0;
        end
      end
      ST_TEST: begin
        if (!creq.start) idx_nxt = idx_r + CW'(1);
      end
      ST_EMIT: begin
        if (go_emit) begin
          // Release the previous edge, keep the new one pending.
          if (pend_r) ov_nxt = 1'b1;
          pend_nxt = 1'b1;
          nedge_nxt = nedge_r + CW'(1);
          idx_nxt = idx_r + CW'(1);
        end
      end
      ST_STORE: begin
        if (!(ov_r && out_stall)) begin
          if (pend_r) ov_nxt = 1'b1;
          pend_nxt = 1'b0;
          if (cnt_r < CW'(MAX_READERS)) cnt_nxt = cnt_r + CW'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      cnt_r <= '0;
      idx_r <= '0;
      nedge_r <= '0;
      pend_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
      nedge_r <= nedge_nxt;
      pend_r <= pend_nxt;
      ov_r <= ov_nxt;
    end
    if (accept) begin
      id_r <= in_node_id;
      x_r <= in_pos_x;
      y_r <= in_pos_y;
      rad_r <= in_coverage;
    end
    if (st_r == ST_DIFF) begin
      dx_r <= sdx[DIFF_W-1] ? DIFF_W'(-sdx) : DIFF_W'(sdx);
      dy_r <= sdy[DIFF_W-1] ? DIFF_W'(-sdy) : DIFF_W'(sdy);
      rs_r <= RS_W'(rad_r) + RS_W'(er);
      eid_r <= eid;
    end
    if (st_r == ST_SQR) begin
      d2_r <= D2_W'(dxx) + D2_W'(dyy);
      rs2_r <= rs_r * rs_r;
    end
    if (go_emit) begin
      pfrom_r <= eid_r;
      pw_r <= crsp.weight;
      if (pend_r) begin
        out_from_reader <= pfrom_r;
        out_weight <= pw_r;
        out_last_of_run <= 1'b0;
        out_to_reader <= id_r;
      end
    end
    if (st_r == ST_STORE && !(ov_r && out_stall) && pend_r) begin
      out_from_reader <= pfrom_r;
      out_weight <= pw_r;
      out_last_of_run <= 1'b1;
      out_to_reader <= id_r;
    end
  end

  assign out_valid = ov_r;

  `AST_IMPL(a_cnt_max, 1'b1, cnt_r <= CW'(MAX_READERS))
  `AST_IMPL(a_idx_in, st_r == ST_READ, idx_r < cnt_r)
  `AST_NEXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_weight))
  `AST_IMPL(a_edges, st_r == ST_SQRT, nedge_r < CW'(MAX_READERS - 1))
endmodule
